// ===== rtl/rfa_pkg.sv =====
// Shared types and constants for the radial falloff alpha generator.
package rfa_pkg;
  localparam int unsigned SideW    = 11;
  localparam int unsigned CoordW   = 10;
  localparam int unsigned MaxSide  = 1024;
  localparam int unsigned FracBits = 16;
  localparam int unsigned DistW    = 22;
  localparam int unsigned SqrtSteps = DistW / 2 + FracBits;
  localparam int unsigned RootW    = SqrtSteps;
  localparam int unsigned RemW     = RootW + 2;
  localparam int unsigned DivW     = SideW + FracBits - 1;
  localparam int unsigned QW       = FracBits;

  typedef struct packed {
    logic              vld;
    logic              oor;
    logic [SideW-1:0]  side;
  } rfa_tag_t;
endpackage

// ===== rtl/radial_falloff_alpha_gen.sv =====
// Top level of the radial falloff alpha generator: pipeline of root and divide cells.
//
// Input stream s_axis_*: one texel coordinate per item, tdata = {row, col}.
// Output stream m_axis_*: one result per item, tdata = alpha, tuser = out_of_range.
// cfg_we_i / cfg_wdata_i write the side length (values above 1024 read as 1024);
// write it only while no item is in flight.
// From acceptance to the result being offered, an item passes the squared-distance
// register, 27 square-root cells (one bit pair each), one compare stage,
// 16 divide cells (one quotient bit each), one multiply stage and the output
// register. Throughput is one item per cycle unless the receiver stalls;
// the whole chain advances together.
// When the receiver stalls with a result waiting, the chain holds and
// s_axis_tready falls in the same cycle; it rises again once the result is taken.
// Reset empties the pipeline and sets the side length to 64.
module radial_falloff_alpha_gen (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [10:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [9:0] col, [19:10] row
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] alpha
  output logic        m_axis_tuser    // [0] out_of_range
);
  import rfa_pkg::*;

  logic [SideW-1:0]  side_q;
  logic              en;
  logic [CoordW-1:0] col, row;
  logic signed [11:0] dx, dy;
  logic [23:0]       sqx, sqy, dsum;

  rfa_tag_t          tag0_q;
  logic [DistW-1:0]  dist_q;

  rfa_tag_t          sq_tag  [SqrtSteps+1];
  logic [DistW-1:0]  sq_d    [SqrtSteps+1];
  logic [RemW-1:0]   sq_rem  [SqrtSteps+1];
  logic [RootW-1:0]  sq_root [SqrtSteps+1];

  rfa_tag_t          dv_tag  [QW+1];
  logic              dv_over [QW+1];
  logic [RootW-1:0]  dv_rem  [QW+1];
  logic [DivW-1:0]   dv_div  [QW+1];
  logic [QW-1:0]     dv_q    [QW+1];

  rfa_tag_t          pre_tag_q, mul_tag_q, out_tag_q;
  logic              pre_over_q;
  logic [RootW-1:0]  pre_rem_q, limit;
  logic [DivW-1:0]   pre_div_q;
  logic [QW:0]       t;
  logic [2*QW+1:0]   t2_q;
  logic [2*QW+9:0]   prod;
  logic [7:0]        alpha_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q <= SideW'(64);
    end else if (cfg_we_i) begin
      side_q <= (cfg_wdata_i > SideW'(MaxSide)) ? SideW'(MaxSide) : cfg_wdata_i;
    end
  end

  assign en            = !out_tag_q.vld || m_axis_tready;
  assign s_axis_tready = en;

  always_comb begin
    col  = s_axis_tdata[9:0];
    row  = s_axis_tdata[19:10];
    dx   = $signed({1'b0, col, 1'b0}) - $signed({1'b0, side_q}) + 12'sd1;
    dy   = $signed({1'b0, row, 1'b0}) - $signed({1'b0, side_q}) + 12'sd1;
    sqx  = 24'(dx * dx);
    sqy  = 24'(dy * dy);
    dsum = sqx + sqy;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag0_q <= '0;
    end else if (en) begin
      tag0_q.vld  <= s_axis_tvalid;
      tag0_q.oor  <= ({1'b0, col} >= side_q) || ({1'b0, row} >= side_q);
      tag0_q.side <= side_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dist_q <= dsum[DistW-1:0];
    end
  end

  assign sq_tag[0]  = tag0_q;
  assign sq_d[0]    = dist_q;
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;

  for (genvar i = 0; i < SqrtSteps; i++) begin : g_sqrt
    rfa_sqrt_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .tag_i  (sq_tag[i]),
      .d_i    (sq_d[i]),
      .rem_i  (sq_rem[i]),
      .root_i (sq_root[i]),
      .tag_o  (sq_tag[i+1]),
      .d_o    (sq_d[i+1]),
      .rem_o  (sq_rem[i+1]),
      .root_o (sq_root[i+1])
    );
  end

  assign limit = {sq_tag[SqrtSteps].side, {FracBits{1'b0}}};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_tag_q <= '0;
    end else if (en) begin
      pre_tag_q <= sq_tag[SqrtSteps];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pre_over_q <= sq_root[SqrtSteps] >= limit;
      pre_rem_q  <= sq_root[SqrtSteps];
      pre_div_q  <= {sq_tag[SqrtSteps].side, {(FracBits-1){1'b0}}};
    end
  end

  assign dv_tag[0]  = pre_tag_q;
  assign dv_over[0] = pre_over_q;
  assign dv_rem[0]  = pre_rem_q;
  assign dv_div[0]  = pre_div_q;
  assign dv_q[0]    = '0;

  for (genvar k = 0; k < QW; k++) begin : g_div
    rfa_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .tag_i  (dv_tag[k]),
      .over_i (dv_over[k]),
      .rem_i  (dv_rem[k]),
      .div_i  (dv_div[k]),
      .q_i    (dv_q[k]),
      .tag_o  (dv_tag[k+1]),
      .over_o (dv_over[k+1]),
      .rem_o  (dv_rem[k+1]),
      .div_o  (dv_div[k+1]),
      .q_o    (dv_q[k+1])
    );
  end

  always_comb begin
    if (dv_over[QW]) begin
      t = '0;
    end else begin
      t = {1'b1, {QW{1'b0}}} - {1'b0, dv_q[QW]};
    end
    prod = {t2_q, 8'h00} - {8'h00, t2_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_tag_q <= '0;
      out_tag_q <= '0;
    end else if (en) begin
      mul_tag_q <= dv_tag[QW];
      out_tag_q <= mul_tag_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      t2_q    <= t * t;
      alpha_q <= mul_tag_q.oor ? 8'h00 : prod[2*FracBits+7:2*FracBits];
    end
  end

  assign m_axis_tvalid = out_tag_q.vld;
  assign m_axis_tdata  = alpha_q;
  assign m_axis_tuser  = out_tag_q.oor;
endmodule

// ===== rtl/rfa_sqrt_cell.sv =====
// One bit-pair step of the scaled integer square root.
module rfa_sqrt_cell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  rfa_pkg::rfa_tag_t         tag_i,
  input  logic [rfa_pkg::DistW-1:0] d_i,
  input  logic [rfa_pkg::RemW-1:0]  rem_i,
  input  logic [rfa_pkg::RootW-1:0] root_i,
  output rfa_pkg::rfa_tag_t         tag_o,
  output logic [rfa_pkg::DistW-1:0] d_o,
  output logic [rfa_pkg::RemW-1:0]  rem_o,
  output logic [rfa_pkg::RootW-1:0] root_o
);
  import rfa_pkg::*;

  rfa_tag_t          tag_q;
  logic [DistW-1:0]  d_q, d_d;
  logic [RemW-1:0]   rem_q, rem_d, rem_sh, trial;
  logic [RootW-1:0]  root_q, root_d;

  always_comb begin
    rem_sh = {rem_i[RemW-3:0], d_i[DistW-1:DistW-2]};
    trial  = {root_i, 2'b01};
    d_d    = {d_i[DistW-3:0], 2'b00};
    if (rem_sh >= trial) begin
      rem_d  = rem_sh - trial;
      root_d = {root_i[RootW-2:0], 1'b1};
    end else begin
      rem_d  = rem_sh;
      root_d = {root_i[RootW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q <= '0;
    end else if (en_i) begin
      tag_q <= tag_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_q    <= d_d;
      rem_q  <= rem_d;
      root_q <= root_d;
    end
  end

  assign tag_o  = tag_q;
  assign d_o    = d_q;
  assign rem_o  = rem_q;
  assign root_o = root_q;
endmodule

// ===== rtl/rfa_div_cell.sv =====
// One quotient bit of the restoring divide by the side length.
module rfa_div_cell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  rfa_pkg::rfa_tag_t         tag_i,
  input  logic                      over_i,
  input  logic [rfa_pkg::RootW-1:0] rem_i,
  input  logic [rfa_pkg::DivW-1:0]  div_i,
  input  logic [rfa_pkg::QW-1:0]    q_i,
  output rfa_pkg::rfa_tag_t         tag_o,
  output logic                      over_o,
  output logic [rfa_pkg::RootW-1:0] rem_o,
  output logic [rfa_pkg::DivW-1:0]  div_o,
  output logic [rfa_pkg::QW-1:0]    q_o
);
  import rfa_pkg::*;

  rfa_tag_t         tag_q;
  logic             over_q;
  logic [RootW-1:0] rem_q, rem_d, div_x;
  logic [DivW-1:0]  div_q;
  logic [QW-1:0]    q_q, q_d;

  always_comb begin
    div_x = {{(RootW-DivW){1'b0}}, div_i};
    if (rem_i >= div_x) begin
      rem_d = rem_i - div_x;
      q_d   = {q_i[QW-2:0], 1'b1};
    end else begin
      rem_d = rem_i;
      q_d   = {q_i[QW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q <= '0;
    end else if (en_i) begin
      tag_q <= tag_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      over_q <= over_i;
      rem_q  <= rem_d;
      div_q  <= {1'b0, div_i[DivW-1:1]};
      q_q    <= q_d;
    end
  end

  assign tag_o  = tag_q;
  assign over_o = over_q;
  assign rem_o  = rem_q;
  assign div_o  = div_q;
  assign q_o    = q_q;
endmodule

// ===== tb/radial_falloff_alpha_gen_checker.sv =====
// Checker for the radial falloff alpha generator: predicts alpha per texel and compares.
module radial_falloff_alpha_gen_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [10:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [7:0]  m_axis_tdata,
  input  logic        m_axis_tuser,
  output int          fail_count_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] alpha;
    logic       oor;
  } texel_res_t;

  logic [10:0] side_q;
  texel_res_t  alpha_q[$];

  function automatic logic [31:0] root_scaled(logic [31:0] d);
    logic [63:0] rem, root, trial, pair;
    rem = 0;
    root = 0;
    for (int i = 0; i < 32; i++) begin
      pair = (i < 16) ? 64'((d >> (2 * (15 - i))) & 32'd3) : 64'd0;
      rem = (rem << 2) | pair;
      trial = (root << 2) | 64'd1;
      if (rem >= trial) begin
        rem = rem - trial;
        root = (root << 1) | 64'd1;
      end else begin
        root = root << 1;
      end
    end
    return root[31:0];
  endfunction

  function automatic texel_res_t texel_alpha(logic [9:0] col, logic [9:0] row,
                                             logic [10:0] side);
    texel_res_t res;
    int          dx, dy;
    logic [31:0] d;
    logic [63:0] q, t, a;
    res = '0;
    if (side == 0 || col >= side || row >= side) begin
      res.oor = 1'b1;
      return res;
    end
    dx = 2 * int'(col) - int'(side) + 1;
    dy = 2 * int'(row) - int'(side) + 1;
    d = 32'(dx * dx) + 32'(dy * dy);
    q = 64'(root_scaled(d)) / 64'(side);
    t = (q >= 64'd65536) ? 64'd0 : 64'd65536 - q;
    a = (t * t * 64'd255) >> 32;
    res.alpha = a[7:0];
    return res;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    texel_res_t exp_r;
    if (!rst_ni) begin
      side_q <= 11'd64;
      fail_count_o <= 0;
      alpha_q.delete();
    end else begin
      if (cfg_we_i) begin
        side_q <= (cfg_wdata_i > 11'd1024) ? 11'd1024 : cfg_wdata_i;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        alpha_q.push_back(texel_alpha(s_axis_tdata[9:0], s_axis_tdata[19:10], side_q));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (alpha_q.size() == 0) begin
          if (fail_count_o < 10) $display("unexpected item: alpha %0d oor %0b",
                                          m_axis_tdata, m_axis_tuser);
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_r = alpha_q.pop_front();
          if (exp_r.alpha !== m_axis_tdata || exp_r.oor !== m_axis_tuser) begin
            if (fail_count_o < 10) $display("mismatch: exp alpha %0d oor %0b, got %0d %0b",
                                            exp_r.alpha, exp_r.oor, m_axis_tdata,
                                            m_axis_tuser);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end

  assign pending_o = alpha_q.size();
endmodule

// ===== tb/radial_falloff_alpha_gen_test.sv =====
// Top of the radial falloff alpha generator testbench: stimulus, back-pressure and verdict.
module radial_falloff_alpha_gen_test;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk_i, rst_ni;
  logic        cfg_we_i;
  logic [10:0] cfg_wdata_i;
  logic        s_axis_tvalid, s_axis_tready;
  logic [23:0] s_axis_tdata;
  logic        m_axis_tvalid, m_axis_tready;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tuser;
  int          fail_count, pending;
  int          src_idle_pct, sink_idle_pct;
  bit          hold_off;
  longint      cycles;

  radial_falloff_alpha_gen DUT (.*);

  radial_falloff_alpha_gen_checker u_checker (
    .*, .fail_count_o(fail_count), .pending_o(pending));

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > 400000) begin
        $display("radial_falloff_alpha_gen test failed");
        $finish;
      end
    end
  end

  always @(posedge clk_i) begin
    if (hold_off) m_axis_tready <= 1'b0;
    else m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
  end

  // tvalid stays up after the accepting edge; the next call drops it or offers the next texel, or the caller drops it
  task automatic send_texel(logic [9:0] col, logic [9:0] row);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0, row, col};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // pending is sampled mid-cycle, clear of the checker's update at the edge
  task automatic wait_drained();
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic write_side(logic [10:0] side);
    s_axis_tvalid <= 1'b0;
    wait_drained();
    repeat (50) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= side;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic send_random(int n, logic [10:0] side);
    int lim;
    for (int i = 0; i < n; i++) begin
      lim = (side > 1 && $urandom_range(9) != 0) ? side + 1 : 1024;
      if (lim > 1024) lim = 1024;
      send_texel(10'($urandom_range(lim - 1)), 10'($urandom_range(lim - 1)));
    end
  endtask

  initial begin
    logic [10:0] sides[7] = '{11'd64, 11'd1, 11'd1024, 11'd2047, 11'd0, 11'd7, 11'd300};
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    m_axis_tready = 1'b0;
    hold_off = 1'b0;
    src_idle_pct = 16;
    sink_idle_pct = 69;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: centre, corners, edges and outside at reset side
    send_texel(10'd31, 10'd31);
    send_texel(10'd32, 10'd32);
    send_texel(10'd0, 10'd0);
    send_texel(10'd63, 10'd63);
    send_texel(10'd0, 10'd32);
    send_texel(10'd64, 10'd0);
    send_texel(10'd0, 10'd64);
    send_texel(10'd1023, 10'd1023);
    send_texel(10'd45, 10'd17);

    // long receiver stall while the sender keeps offering
    fork
      begin
        hold_off = 1'b1;
        repeat (300) @(posedge clk_i);
        hold_off = 1'b0;
      end
      send_random(120, 11'd64);
    join

    for (int p = 0; p < 7; p++) begin
      if (p == 3) begin src_idle_pct = 69; sink_idle_pct = 16; end
      if (p == 5) begin src_idle_pct = 0; sink_idle_pct = 0; end
      write_side(sides[p]);
      if (p == 2) begin
        send_texel(10'd511, 10'd512);
        send_texel(10'd1023, 10'd0);
        send_texel(10'd0, 10'd1023);
      end
      send_random(230, sides[p] > 11'd1024 ? 11'd1024 : sides[p]);
    end

    s_axis_tvalid <= 1'b0;
    wait_drained();
    repeat (60) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("radial_falloff_alpha_gen test passed");
    end else begin
      $display("radial_falloff_alpha_gen test failed");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
rtl/rfa_pkg.sv
rtl/rfa_sqrt_cell.sv
rtl/rfa_div_cell.sv
rtl/radial_falloff_alpha_gen.sv
tb/radial_falloff_alpha_gen_checker.sv
tb/radial_falloff_alpha_gen_test.sv
